// ----- sv/b64enc_pkg.sv -----
// b64enc_pkg: shared types and the base64 alphabet for the stream encoder.
// No dependencies; imported by every module of the encoder.
`timescale 1ns / 1ps

package b64enc_pkg;

    localparam logic [6:0] PAD_CHAR   = 7'h3D;  // '='
    localparam logic [6:0] PLUS_CHAR  = 7'h2B;  // '+'
    localparam logic [6:0] SLASH_CHAR = 7'h2F;  // '/'

    // One byte's worth of output: up to four characters.
    typedef struct packed {
        logic [1:0]      last_idx;  // number of characters minus one
        logic            eot;       // final character closes the message
        logic [3:0][6:0] chars;
    } b64enc_job_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] v7;
        v7 = {1'b0, v};
        if (v < 6'd26)
            sextet_char = v7 + 7'd65;   // 'A'..'Z'
        else if (v < 6'd52)
            sextet_char = v7 + 7'd71;   // 'a'..'z'
        else if (v < 6'd62)
            sextet_char = v7 - 7'd4;    // '0'..'9'
        else if (v == 6'd62)
            sextet_char = PLUS_CHAR;
        else
            sextet_char = SLASH_CHAR;
    endfunction

endpackage

// ----- sv/b64enc_front.sv -----
// b64enc_front: accepts bytes, tracks group phase and leftover bits,
// and builds the character word for each byte. Depends on b64enc_pkg.
`timescale 1ns / 1ps

module b64enc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  logic                   q_full,
    output logic                   wr_en,
    output b64enc_pkg::b64enc_job_t job
);
    import b64enc_pkg::*;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    logic [3:0] left_reg, left_next;
    logic [1:0] phase_reg, phase_next;
    logic [3:0] left_after;
    logic [1:0] phase_after;

    assign wr_en = push && !q_full;

    always_comb
    begin
        job          = '0;
        job.eot      = last_byte;
        left_after   = '0;
        phase_after  = PH_FIRST;
        case (phase_reg)
            PH_SECOND:
            begin
                job.chars[0] = sextet_char({left_reg[1:0], data_byte[7:4]});
                job.last_idx = 2'd0;
                left_after   = data_byte[3:0];
                phase_after  = PH_THIRD;
            end
            PH_THIRD:
            begin
                job.chars[0] = sextet_char({left_reg, data_byte[7:6]});
                job.chars[1] = sextet_char(data_byte[5:0]);
                job.last_idx = 2'd1;
                left_after   = '0;
                phase_after  = PH_FIRST;
            end
            default:
            begin
                job.chars[0] = sextet_char(data_byte[7:2]);
                job.last_idx = 2'd0;
                left_after   = {2'b00, data_byte[1:0]};
                phase_after  = PH_SECOND;
            end
        endcase

        // flush leftover bits and pad the group out to four characters
        if (last_byte)
        begin
            if (phase_after == PH_SECOND)
            begin
                job.chars[1] = sextet_char({left_after[1:0], 4'b0000});
                job.chars[2] = PAD_CHAR;
                job.chars[3] = PAD_CHAR;
                job.last_idx = 2'd3;
            end
            else if (phase_after == PH_THIRD)
            begin
                job.chars[1] = sextet_char({left_after, 2'b00});
                job.chars[2] = PAD_CHAR;
                job.last_idx = 2'd2;
            end
        end

        left_next  = left_reg;
        phase_next = phase_reg;
        if (wr_en)
        begin
            left_next  = last_byte ? 4'd0 : left_after;
            phase_next = last_byte ? PH_FIRST : phase_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            phase_reg <= PH_FIRST;
        end
        else
        begin
            left_reg  <= left_next;
            phase_reg <= phase_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("front phase left the three-byte group");
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && last_byte) |=> (phase_reg == PH_FIRST && left_reg == 4'd0))
        else $error("state not cleared after last byte");
    a_first_no_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FIRST) |-> (left_reg == 4'd0))
        else $error("leftover bits held at start of group");
`endif

endmodule

// ----- sv/b64enc_fifo.sv -----
// b64enc_fifo: short register queue of character words between front and back.
// Depends on b64enc_pkg.
`timescale 1ns / 1ps

module b64enc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  b64enc_pkg::b64enc_job_t wr_data,
    input  logic                   rd_en,
    output b64enc_pkg::b64enc_job_t rd_data,
    output logic                   full,
    output logic                   empty
);
    import b64enc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    b64enc_job_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && empty))
        else $error("read from empty queue");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("write to full queue");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow write");
`endif

endmodule

// ----- sv/b64enc_back.sv -----
// b64enc_back: walks the characters of the head word and presents them one
// per cycle through an output register while pop takes each. Depends on b64enc_pkg.
`timescale 1ns / 1ps

module b64enc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  b64enc_pkg::b64enc_job_t head,
    input  logic                   q_empty,
    output logic                   rd_en,
    input  logic                   pop,
    output logic                   empty,
    output logic [6:0]             ascii_char,
    output logic                   end_of_text
);
    import b64enc_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [6:0] char_reg, char_next;
    logic       eot_reg, eot_next;
    logic       load, take, at_last;

    // output slot frees when empty or when its word is taken this cycle
    assign load    = !valid_reg || pop;
    assign take    = load && !q_empty;
    assign at_last = (idx_reg == head.last_idx);
    assign rd_en   = take && at_last;

    assign empty       = !valid_reg;
    assign ascii_char  = char_reg;
    assign end_of_text = eot_reg;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        eot_next   = eot_reg;
        if (take)
        begin
            idx_next   = at_last ? 2'd0 : idx_reg + 1'b1;
            valid_next = 1'b1;
            char_next  = head.chars[idx_reg];
            eot_next   = head.eot && at_last;
        end
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        eot_reg  <= eot_next;
    end

`ifndef NO_ASSERTIONS
    a_idx_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (idx_reg <= head.last_idx))
        else $error("character index past end of word");
    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> (idx_reg == 2'd0))
        else $error("character index held with no word queued");
    a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && head.eot && at_last) |=> (valid_reg && eot_reg && idx_reg == 2'd0))
        else $error("final character not flagged");
`endif

endmodule

// ----- sv/base64_stream_encoder_unit.sv -----
// base64_stream_encoder_unit: top level of the streaming base64 encoder.
// A byte taken is written into the queue; its first character then loads into the output register.
// Throughput: one byte per cycle while the queue has room; one character per cycle out while pop
//   takes each, so the sustained byte rate is limited by the single output register.
// Reset: rst_n clears phase, leftover bits, queue and output at once; no clearing pass.
// Depends on b64enc_pkg, b64enc_front, b64enc_fifo, b64enc_back.
`timescale 1ns / 1ps

module base64_stream_encoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] ascii_char,
    output logic       end_of_text
);
    import b64enc_pkg::*;

    b64enc_job_t wr_job;
    b64enc_job_t head_job;
    logic        wr_en;
    logic        rd_en;
    logic        q_full;
    logic        q_empty;

    assign full = q_full;

    b64enc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .wr_en     (wr_en),
        .job       (wr_job)
    );

    b64enc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_job),
        .rd_en   (rd_en),
        .rd_data (head_job),
        .full    (q_full),
        .empty   (q_empty)
    );

    b64enc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_job),
        .q_empty     (q_empty),
        .rd_en       (rd_en),
        .pop         (pop),
        .empty       (empty),
        .ascii_char  (ascii_char),
        .end_of_text (end_of_text)
    );

endmodule

// ----- verif/base64_stream_checker.sv -----
// base64_stream_checker: watches the byte and character channels of the encoder,
// predicts the character stream and compares it word by word. Uses b64enc_pkg.
`timescale 1ns / 1ps

module base64_stream_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       empty,
    input  logic       pop,
    input  logic [6:0] ascii_char,
    input  logic       end_of_text,
    output int         error_count,
    output int         pending_count,
    output int         checked_count
);

    typedef enum logic [1:0] {GRP_FIRST, GRP_SECOND, GRP_THIRD} grp_pos_t;

    typedef struct packed {
        logic [6:0] code;
        logic       eot;
    } b64_word_t;

    grp_pos_t  grp_pos;
    logic [3:0] carry_bits;
    b64_word_t pending_chars[$];
    int        errs;
    int        matched;

    function automatic logic [6:0] b64_symbol(input logic [5:0] v);
        string alphabet;
        byte   c;
        alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        c = alphabet[v];
        return c[6:0];
    endfunction

    task automatic add_char(input logic [6:0] code);
        b64_word_t w;
        w.code = code;
        w.eot  = 1'b0;
        pending_chars = {pending_chars, w};
    endtask

    // Expected characters for one accepted byte, flush and padding included.
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        case (grp_pos)
            GRP_SECOND:
            begin
                add_char(b64_symbol({carry_bits[1:0], b[7:4]}));
                carry_bits = b[3:0];
                grp_pos    = GRP_THIRD;
            end
            GRP_THIRD:
            begin
                add_char(b64_symbol({carry_bits, b[7:6]}));
                add_char(b64_symbol(b[5:0]));
                carry_bits = 4'd0;
                grp_pos    = GRP_FIRST;
            end
            default:
            begin
                add_char(b64_symbol(b[7:2]));
                carry_bits = {2'b00, b[1:0]};
                grp_pos    = GRP_SECOND;
            end
        endcase
        if (fin)
        begin
            if (grp_pos == GRP_SECOND)
            begin
                add_char(b64_symbol({carry_bits[1:0], 4'b0000}));
                add_char(b64enc_pkg::PAD_CHAR);
                add_char(b64enc_pkg::PAD_CHAR);
            end
            else if (grp_pos == GRP_THIRD)
            begin
                add_char(b64_symbol({carry_bits, 2'b00}));
                add_char(b64enc_pkg::PAD_CHAR);
            end
            pending_chars[pending_chars.size() - 1].eot = 1'b1;
            carry_bits = 4'd0;
            grp_pos    = GRP_FIRST;
        end
    endtask

    task automatic check_char();
        b64_word_t want;
        if (pending_chars.size() == 0)
        begin
            if (errs < 10)
                $display("%0t: unexpected word 0x%h eot %b, nothing pending",
                         $realtime, ascii_char, end_of_text);
            errs++;
        end
        else
        begin
            want = pending_chars.pop_front();
            if (want.code !== ascii_char || want.eot !== end_of_text)
            begin
                if (errs < 10)
                    $display("%0t: char mismatch: expected 0x%h eot %b, got 0x%h eot %b",
                             $realtime, want.code, want.eot, ascii_char, end_of_text);
                errs++;
            end
            else
                matched++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_pos    = GRP_FIRST;
            carry_bits = 4'd0;
            pending_chars.delete();
            errs       = 0;
            matched    = 0;
            error_count   <= 0;
            pending_count <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (pop && !empty)
                check_char();
            if (push && !full)
                encode_byte(data_byte, last_byte);
            error_count   <= errs;
            pending_count <= pending_chars.size();
            checked_count <= matched;
        end
    end

endmodule

// ----- verif/tb_base64_stream_encoder_unit.sv -----
// tb_base64_stream_encoder_unit: stimulus and verdict for the base64 stream encoder.
// Depends on base64_stream_encoder_unit and base64_stream_checker.
`timescale 1ns / 1ps

module tb_base64_stream_encoder_unit;

    localparam int RANDOM_BYTES = 210;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_DIRECTED   = 18;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [6:0] ascii_char;
    logic       end_of_text;
    logic       hold_off = 1'b0;

    int error_count;
    int pending_count;
    int checked_count;
    int cycle_count = 0;
    int bytes_sent = 0;
    int msg_count = 0;

    // {last, byte}: single-byte messages, "Ma", "Man", all-ones, '+' and '/' sextets
    logic [8:0] directed_bytes [N_DIRECTED] = '{
        9'h100, 9'h1FF, 9'h04D, 9'h161, 9'h04D, 9'h061, 9'h16E, 9'h0FF, 9'h0FF,
        9'h1FF, 9'h0F8, 9'h000, 9'h000, 9'h0FC, 9'h110, 9'h0FB, 9'h0EF, 9'h1BE
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    base64_stream_encoder_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .empty       (empty),
        .pop         (pop),
        .ascii_char  (ascii_char),
        .end_of_text (end_of_text)
    );

    base64_stream_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .empty         (empty),
        .pop           (pop),
        .ascii_char    (ascii_char),
        .end_of_text   (end_of_text),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
        if (fin)
            msg_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words pending", cycle_count, pending_count);
            $display("base64_stream_encoder_unit verification failed");
            $finish;
        end
    end

    // long output hold-off so the queue fills and full backs up the sender
    initial
    begin
        repeat (250) @(posedge clk);
        hold_off <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        int stall_left;
        int burst_left;
        stall_left = 0;
        burst_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && burst_left == 0)
            begin
                stall_left = pick_gap();
                burst_left = $urandom_range(1, 24);
            end
            if (hold_off)
                pop <= 1'b0;
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                burst_left--;
            end
        end
    end

    initial
    begin
        int msg_len;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

        while (bytes_sent < N_DIRECTED + RANDOM_BYTES)
        begin
            msg_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6)
                                                   : $urandom_range(7, 20);
            for (int i = 0; i < msg_len; i++)
                send_byte(8'($urandom_range(0, 255)), i == msg_len - 1);
        end
        push      <= 1'b0;
        last_byte <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("encoded %0d bytes in %0d messages, %0d characters matched,",
                 bytes_sent, msg_count, checked_count);
        $display("with random gaps on both sides and one long output hold-off");
        if (error_count == 0 && pending_count == 0)
            $display("base64_stream_encoder_unit verification clean");
        else
            $display("base64_stream_encoder_unit verification failed");
        $finish;
    end

endmodule
